// File: hw/rtl/dbwf_pkg.sv
`timescale 1ns / 1ps

package dbwf_pkg;

  // Fixed field widths.
  localparam int DEPTH_W    = 32;
  localparam int LEVEL_W    = 6;
  localparam int COLUMN_W   = 22;
  localparam int INDEX_W    = 28;
  localparam int WEIGHT_W   = 17;
  localparam int LC_W       = 7;
  localparam int SL_W       = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Quotient bits of the weight divide and its step counter.
  localparam int Q_BITS = 16;
  localparam int CNT_W  = $clog2(Q_BITS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(Q_BITS - 1);

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1 << Q_BITS);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = '0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LEN   = CFG_IDX_W'(1);

  localparam logic [LC_W-1:0] LEVEL_COUNT_RST = LC_W'(2);
  localparam logic [SL_W-1:0] SLICE_LEN_RST   = SL_W'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;     // latch the query word
    logic load_we;    // write a load word into the table
    logic init_k;     // start the walk at the (clamped) bracket level
    logic rd_mid;     // read the middle table entry
    logic rd_sweep;   // read at the sweep index
    logic sw_clear;   // clear the sweep index
    logic sw_write;   // write back a negated entry and advance
    logic cap_ab;     // capture the bracket pair
    logic k_dec;
    logic k_inc;
    logic sub;        // form the differences and the lower index
    logic prep;       // classify the ratio, form the upper index
    logic div_step;   // one restoring divide step
    logic finish;     // update the bracket level
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mid_pos;
    logic sweep_last;
    logic a_lt_t;
    logic a_le_t;
    logic b_ge_t;
    logic k_zero;
    logic k_top;
    logic div_needed;
  } dp_stat_t;

  // Negation that maps the most negative value to the most positive one.
  function automatic logic signed [DEPTH_W-1:0] neg_sat(input logic signed [DEPTH_W-1:0] v);
    logic signed [DEPTH_W-1:0] r;
    if (v == {1'b1, {(DEPTH_W-1){1'b0}}}) begin
      r = {1'b0, {(DEPTH_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/depth_bracket_weight_finder_unit.sv
`timescale 1ns / 1ps

// Load word: written into the level table at the accepting edge; busy stays low.
// Query word: done pulses after the middle-entry check, the sign flip of the
// table when its middle level is positive, the bracket walk and, when the
// weight needs it, the serial divide. One query in flight at a time.
// The receiver cannot stall: each result word is valid for the one done cycle.
// Synchronous active-high reset: level_count = 2, slice_len = 1, bracket level 0.
module depth_bracket_weight_finder_unit #(
  parameter int MAX_LEVELS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [dbwf_pkg::LEVEL_W-1:0]        level,
  input  logic signed [dbwf_pkg::DEPTH_W-1:0] depth_value,
  input  logic [dbwf_pkg::COLUMN_W-1:0]       column,
  input  logic                                last_point,
  // Result channel.
  output logic                                done,
  output logic [dbwf_pkg::INDEX_W-1:0]        lower_index,
  output logic [dbwf_pkg::INDEX_W-1:0]        upper_index,
  output logic [dbwf_pkg::WEIGHT_W-1:0]       lower_weight,
  output logic                                last_point_res,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbwf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import dbwf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  // The register file takes a configuration word in every cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The controller sequences the middle-entry check, the optional sign-flip
  // sweep (a read then a write-back for each level), the bracket walk
  // (one table read of both neighbors per step) and the 16-step divide.
  dbwf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath holds the level table, the configuration registers, the
  // bracket level, the index arithmetic and the restoring divider.
  dbwf_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .level          (level),
    .depth_value    (depth_value),
    .column         (column),
    .last_point     (last_point),
    .cmd            (cmd),
    .stat           (stat),
    .lower_index    (lower_index),
    .upper_index    (upper_index),
    .lower_weight   (lower_weight),
    .last_point_res (last_point_res)
  );

  // A result word is only presented once the query has fully retired.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while a query is still in progress");

  // The weight never exceeds one in Q1.16.
  assert property (@(posedge clk) disable iff (rst) done |-> (lower_weight <= WEIGHT_ONE))
    else $error("lower_weight above one");

  // An accepted query occupies the block in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy && action) |=> busy)
    else $error("query accepted but block not busy");

  // A load is finished at its accepting edge and produces no result.
  assert property (@(posedge clk) disable iff (rst)
      (start && !busy && !action) |=> (!busy && !done))
    else $error("load word disturbed the controller");

endmodule

// File: hw/rtl/dbwf_ram.sv
`timescale 1ns / 1ps

module dbwf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/dbwf_ctrl.sv
`timescale 1ns / 1ps

module dbwf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               action,
  input  dbwf_pkg::dp_stat_t stat,
  output dbwf_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  import dbwf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MID, S_MIDCHK, S_SW_RD, S_SW_WR,
    S_WK_RD, S_WK_CHK, S_SUB, S_PREP, S_DIV
  } state_t;

  typedef enum logic [1:0] {M_NONE, M_DOWN, M_UP} mode_t;

  state_t           state, state_next;
  mode_t            mode, mode_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             done_next;

  always_comb begin
    logic dec;
    logic inc;
    dec        = 1'b0;
    inc        = 1'b0;
    cmd        = '0;
    state_next = state;
    mode_next  = mode;
    cnt_next   = cnt;
    done_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.cap_in  = start;
        cmd.load_we = start && !action;
        if (start && action) begin
          state_next = S_MID;
        end
      end
      S_MID: begin
        cmd.init_k = 1'b1;
        cmd.rd_mid = 1'b1;
        mode_next  = M_NONE;
        state_next = S_MIDCHK;
      end
      S_MIDCHK: begin
        if (stat.mid_pos) begin
          cmd.sw_clear = 1'b1;
          state_next   = S_SW_RD;
        end else begin
          state_next = S_WK_RD;
        end
      end
      S_SW_RD: begin
        cmd.rd_sweep = 1'b1;
        state_next   = S_SW_WR;
      end
      S_SW_WR: begin
        cmd.rd_sweep = 1'b1;
        cmd.sw_write = 1'b1;
        state_next   = stat.sweep_last ? S_WK_RD : S_SW_RD;
      end
      S_WK_RD: begin
        state_next = S_WK_CHK;
      end
      S_WK_CHK: begin
        cmd.cap_ab = 1'b1;
        // The first look fixes the direction; the two directions end on
        // different tie rules.
        unique case (mode)
          M_NONE: begin
            if (stat.a_lt_t) begin
              mode_next = M_DOWN;
              dec       = !stat.k_zero;
            end else if (stat.b_ge_t) begin
              mode_next = M_UP;
              inc       = !stat.k_top;
            end
          end
          M_DOWN:  dec = !stat.k_zero && stat.a_le_t;
          M_UP:    inc = !stat.k_top && stat.b_ge_t;
          default: ;
        endcase
        cmd.k_dec  = dec;
        cmd.k_inc  = inc;
        state_next = (dec || inc) ? S_WK_RD : S_SUB;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_next = '0;
        if (stat.div_needed) begin
          state_next = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == DIV_LAST) begin
          cmd.finish = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_NONE;
      cnt   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      cnt   <= cnt_next;
      busy  <= (state_next != S_IDLE);
      done  <= done_next;
    end
  end

endmodule

// File: hw/rtl/dbwf_dp.sv
`timescale 1ns / 1ps

module dbwf_dp #(
  parameter int MAX_LEVELS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dbwf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dbwf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [dbwf_pkg::LEVEL_W-1:0]          level,
  input  logic signed [dbwf_pkg::DEPTH_W-1:0]   depth_value,
  input  logic [dbwf_pkg::COLUMN_W-1:0]         column,
  input  logic                                  last_point,
  input  dbwf_pkg::dp_cmd_t                     cmd,
  output dbwf_pkg::dp_stat_t                    stat,
  output logic [dbwf_pkg::INDEX_W-1:0]          lower_index,
  output logic [dbwf_pkg::INDEX_W-1:0]          upper_index,
  output logic [dbwf_pkg::WEIGHT_W-1:0]         lower_weight,
  output logic                                  last_point_res
);

  import dbwf_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int NW = $clog2(MAX_LEVELS + 1);
  localparam int PW = LW + SL_W;
  localparam int XW = (PW > INDEX_W) ? PW : INDEX_W;

  // Configuration and persistent state.
  logic [LC_W-1:0] level_count;
  logic [SL_W-1:0] slice_len;
  logic [LW-1:0]   bracket;

  // Per-query registers.
  logic [LW-1:0]              k;
  logic [LW-1:0]              sw_idx;
  logic signed [DEPTH_W-1:0]  t_r;
  logic [COLUMN_W-1:0]        col_r;
  logic                       last_r;
  logic signed [DEPTH_W-1:0]  a_r;
  logic signed [DEPTH_W-1:0]  b_r;
  logic signed [DEPTH_W:0]    den_r;
  logic signed [DEPTH_W:0]    p_r;
  logic [DEPTH_W-1:0]         rem_r;
  logic [DEPTH_W-1:0]         dvs_r;
  logic [WEIGHT_W-1:0]        w_r;
  logic [INDEX_W-1:0]         lo_r;
  logic [INDEX_W-1:0]         hi_r;

  // Table port signals.
  logic               ram_we;
  logic [LW-1:0]      ram_waddr;
  logic [DEPTH_W-1:0] ram_wdata;
  logic [LW-1:0]      raddr_a;
  logic [LW-1:0]      raddr_b;
  logic [DEPTH_W-1:0] rdata_a;
  logic [DEPTH_W-1:0] rdata_b;

  logic [NW-1:0]      n_lv;
  logic [NW-1:0]      n_m2;
  logic [LW-1:0]      mid;
  logic [LW-1:0]      k_start;
  logic               load_ok;

  logic               dneg;
  logic signed [DEPTH_W:0] dn;
  logic signed [DEPTH_W:0] pn;
  logic               den_zero;
  logic               p_nonpos;
  logic               p_ge;

  logic [DEPTH_W:0]   rem2;
  logic [DEPTH_W:0]   rem_diff;
  logic               q_bit;

  logic [PW-1:0]      prod;
  logic [XW-1:0]      lo_full;

  // Effective level count, clamped to 2..MAX_LEVELS.
  always_comb begin
    if (level_count < LC_W'(2)) begin
      n_lv = NW'(2);
    end else if ({{(32-LC_W){1'b0}}, level_count} > 32'(MAX_LEVELS)) begin
      n_lv = NW'(MAX_LEVELS);
    end else begin
      n_lv = NW'(level_count);
    end
  end

  assign n_m2    = n_lv - NW'(2);
  assign mid     = LW'(n_lv >> 1);
  assign k_start = (NW'(bracket) > n_m2) ? LW'(n_m2) : bracket;
  assign load_ok = {{(32-LEVEL_W){1'b0}}, level} < 32'(MAX_LEVELS);

  // Table addressing.
  assign raddr_a   = cmd.rd_mid ? mid : (cmd.rd_sweep ? sw_idx : k);
  assign raddr_b   = k + LW'(1);
  assign ram_we    = cmd.sw_write || (cmd.load_we && load_ok);
  assign ram_waddr = cmd.sw_write ? sw_idx : LW'(level);
  assign ram_wdata = cmd.sw_write ? neg_sat($signed(rdata_a)) : depth_value;

  dbwf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_LEVELS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Ratio classification from the registered differences.
  assign dneg     = den_r[DEPTH_W];
  assign dn       = dneg ? -den_r : den_r;
  assign pn       = dneg ? -p_r : p_r;
  assign den_zero = (den_r == '0);
  assign p_nonpos = (pn <= 0);
  assign p_ge     = (pn >= dn);

  // Restoring divide step.
  assign rem2     = {rem_r, 1'b0};
  assign rem_diff = rem2 - {1'b0, dvs_r};
  assign q_bit    = (rem2 >= {1'b0, dvs_r});

  // Flat index of the lower bracket level.
  assign prod    = {{SL_W{1'b0}}, k} * {{LW{1'b0}}, slice_len};
  assign lo_full = XW'(prod) + XW'(col_r);

  always_comb begin
    stat            = '0;
    stat.mid_pos    = $signed(rdata_a) > 0;
    stat.sweep_last = (NW'(sw_idx) == n_lv - NW'(1));
    stat.a_lt_t     = $signed(rdata_a) < t_r;
    stat.a_le_t     = $signed(rdata_a) <= t_r;
    stat.b_ge_t     = $signed(rdata_b) >= t_r;
    stat.k_zero     = (k == '0);
    stat.k_top      = (NW'(k) == n_m2);
    stat.div_needed = !den_zero && !p_nonpos && !p_ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LEVEL_COUNT_RST;
      slice_len   <= SLICE_LEN_RST;
      bracket     <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_LEVEL_COUNT) begin
        level_count <= cfg_data[LC_W-1:0];
      end
      if (cfg_we && cfg_index == REG_SLICE_LEN) begin
        slice_len <= cfg_data[SL_W-1:0];
      end
      if (cmd.finish) begin
        bracket <= last_r ? '0 : k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      t_r    <= depth_value;
      col_r  <= column;
      last_r <= last_point;
    end
    if (cmd.init_k) begin
      k <= k_start;
    end else if (cmd.k_dec) begin
      k <= k - LW'(1);
    end else if (cmd.k_inc) begin
      k <= k + LW'(1);
    end
    if (cmd.sw_clear) begin
      sw_idx <= '0;
    end else if (cmd.sw_write) begin
      sw_idx <= sw_idx + LW'(1);
    end
    if (cmd.cap_ab) begin
      a_r <= $signed(rdata_a);
      b_r <= $signed(rdata_b);
    end
    if (cmd.sub) begin
      den_r <= {b_r[DEPTH_W-1], b_r} - {a_r[DEPTH_W-1], a_r};
      p_r   <= {b_r[DEPTH_W-1], b_r} - {t_r[DEPTH_W-1], t_r};
      lo_r  <= lo_full[INDEX_W-1:0];
    end
    if (cmd.prep) begin
      hi_r  <= lo_r + {{(INDEX_W-SL_W){1'b0}}, slice_len};
      rem_r <= pn[DEPTH_W-1:0];
      dvs_r <= dn[DEPTH_W-1:0];
      if (den_zero || (!p_nonpos && p_ge)) begin
        w_r <= WEIGHT_ONE;
      end else begin
        w_r <= WEIGHT_ZERO;
      end
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_diff[DEPTH_W-1:0] : rem2[DEPTH_W-1:0];
      w_r   <= {w_r[WEIGHT_W-2:0], q_bit};
    end
  end

  assign lower_index    = lo_r;
  assign upper_index    = hi_r;
  assign lower_weight   = w_r;
  assign last_point_res = last_r;

endmodule

// File: test/depth_bracket_weight_finder_unit_tb.sv
`timescale 1ns / 1ps

module depth_bracket_weight_finder_unit_tb;
  import dbwf_pkg::*;

  // The clock runs at 50 MHz. The cycle limit is several times the slowest
  // legal run: about 500 words, each a query that sign flips and walks all
  // 64 levels and needs the divide, plus the sender's gaps.
  localparam int  TABLE_DEPTH  = 64;
  localparam int  CYCLE_LIMIT  = 1_000_000;
  localparam int  RANDOM_WORDS = 450;
  // Bound on the longest query: a sign flip and walk over all levels and the divide.
  localparam int  QUERY_LATENCY = 300;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

  // One result word of the block.
  typedef struct packed {
    logic [INDEX_W-1:0]  lo;
    logic [INDEX_W-1:0]  hi;
    logic [WEIGHT_W-1:0] w;
    logic                last;
  } bracket_res_t;

  // One row of the directed plan: a load word, a query word or a register write.
  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_SETREG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [LEVEL_W-1:0]  addr;
    logic [DEPTH_W-1:0]  value;
    logic [COLUMN_W-1:0] col;
    logic                last;
    logic                typed;
    bracket_res_t        want;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       action;
  logic [LEVEL_W-1:0]         level;
  logic signed [DEPTH_W-1:0]  depth_value;
  logic [COLUMN_W-1:0]        column;
  logic                       last_point;
  logic                       done;
  logic [INDEX_W-1:0]         lower_index;
  logic [INDEX_W-1:0]         upper_index;
  logic [WEIGHT_W-1:0]        lower_weight;
  logic                       last_point_res;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  depth_bracket_weight_finder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .level          (level),
    .depth_value    (depth_value),
    .column         (column),
    .last_point     (last_point),
    .done           (done),
    .lower_index    (lower_index),
    .upper_index    (upper_index),
    .lower_weight   (lower_weight),
    .last_point_res (last_point_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  // Our own copy of the block's state: the level table, the bracket level
  // that the next walk starts from, and the two configuration registers.
  logic signed [DEPTH_W-1:0] depth_tbl [TABLE_DEPTH];
  int unsigned               bracket;
  logic [LC_W-1:0]           lc_reg;
  logic [SL_W-1:0]           sl_reg;

  // Results predicted at the accepting edge of each query word, oldest first.
  bracket_res_t pending_brackets [$];
  plan_row_t    plan [$];
  logic signed [DEPTH_W-1:0] profile [TABLE_DEPTH];

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;

  // The level count register saturates into 2..64 when it is used.
  function automatic int eff_levels();
    int n;
    n = lc_reg;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  // Weight of the lower-bracket level: floor(65536*(b-t)/(b-a)), held to 0..1.
  // Equal neighbours give the full weight.
  function automatic logic [WEIGHT_W-1:0] ratio_weight(longint t, longint a, longint b);
    longint den, p;
    den = b - a;
    p   = b - t;
    if (den == 0) return WEIGHT_ONE;
    if (den < 0) begin
      den = -den;
      p   = -p;
    end
    if (p <= 0) return WEIGHT_ZERO;
    if (p >= den) return WEIGHT_ONE;
    return WEIGHT_W'((p << 16) / den);
  endfunction

  // Work out the result of one query word and advance the bracket state.
  function automatic bracket_res_t resolve_query(logic signed [DEPTH_W-1:0] t,
                                                 logic [COLUMN_W-1:0] col, logic lp);
    bracket_res_t r;
    int           n, k, i;
    longint       lo, hi;
    n = eff_levels();
    // A positive middle level means the table was loaded as positive depths;
    // the block negates the whole active part, saturating the minimum.
    if (depth_tbl[n >> 1] > 0) begin
      for (i = 0; i < n; i++)
        depth_tbl[i] = (depth_tbl[i] == DEPTH_MIN) ? DEPTH_MAX : -depth_tbl[i];
    end
    k = bracket;
    if (k > n - 2) k = n - 2;
    // Walking down stops on a strictly greater level, walking up on a
    // strictly smaller one, so the two directions treat ties differently.
    if (depth_tbl[k] < t) begin
      while (k > 0 && depth_tbl[k] <= t) k--;
    end else if (depth_tbl[k+1] >= t) begin
      while (k + 1 < n - 1 && depth_tbl[k+1] >= t) k++;
    end
    r.w    = ratio_weight(longint'(t), longint'(depth_tbl[k]), longint'(depth_tbl[k+1]));
    lo     = longint'(k) * longint'(sl_reg) + longint'(col);
    hi     = longint'(k + 1) * longint'(sl_reg) + longint'(col);
    r.lo   = lo[INDEX_W-1:0];
    r.hi   = hi[INDEX_W-1:0];
    r.last = lp;
    bracket = lp ? 0 : k;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Present one word and hold it until the block takes it. A typed
  // expectation replaces the predicted one, but the predictor still runs so
  // that its state follows the block.
  task automatic send_word(input logic act, input logic [LEVEL_W-1:0] lvl,
                           input logic signed [DEPTH_W-1:0] dv,
                           input logic [COLUMN_W-1:0] col, input logic lp,
                           input logic typed, input bracket_res_t typed_res);
    bracket_res_t pred;
    start       <= 1'b1;
    action      <= act;
    level       <= lvl;
    depth_value <= dv;
    column      <= col;
    last_point  <= lp;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (act == ACT_LOAD) begin
      depth_tbl[lvl] = dv;
    end else begin
      pred = resolve_query(dv, col, lp);
      pending_brackets.push_back(typed ? typed_res : pred);
    end
  endtask

  // Sender gaps: about 22 words in a hundred, except during the calm stretch.
  task automatic pause_maybe();
    if (!calm && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Registers change only with the block idle. Loads finish at their
  // accepting edge, so the block is idle once the last result is in.
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending_brackets.size() != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LEVEL_COUNT) lc_reg = data[LC_W-1:0];
    else if (idx == REG_SLICE_LEN) sl_reg = data[SL_W-1:0];
  endtask

  task automatic cfg_gap_maybe();
    if ($urandom_range(0, 99) < 22) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic void add_row(row_kind_t kind, logic [LEVEL_W-1:0] addr,
                                  logic [DEPTH_W-1:0] value, logic [COLUMN_W-1:0] col,
                                  logic lp, logic typed, logic [INDEX_W-1:0] lo,
                                  logic [INDEX_W-1:0] hi, logic [WEIGHT_W-1:0] w);
    plan.push_back({kind, addr, value, col, lp, typed, lo, hi, w, lp});
  endfunction

  // A fresh set of levels. Most are monotonic with random spacing, going
  // either way so that both the sign flip and the plain table occur; a few
  // neighbours are equal. The rest is noise with the extremes mixed in.
  function automatic void make_profile();
    longint v, dir;
    int     i;
    if ($urandom_range(0, 99) < 75) begin
      v   = longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000;
      dir = $urandom_range(0, 1) ? 1 : -1;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        profile[i] = DEPTH_W'(v);
        if ($urandom_range(0, 99) >= 8) v = v + dir * longint'($urandom_range(1, 1 << 22));
      end
    end else begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        case ($urandom_range(0, 9))
          0: profile[i] = DEPTH_MIN;
          1: profile[i] = DEPTH_MAX;
          default: profile[i] = $urandom;
        endcase
      end
    end
  endfunction

  // A target near the active table: mostly between two neighbours, often
  // exactly on a level, sometimes outside the span, sometimes anything.
  function automatic logic signed [DEPTH_W-1:0] pick_target(int n);
    longint a, b, t;
    int     i, r;
    i = $urandom_range(0, n - 2);
    a = depth_tbl[i];
    b = depth_tbl[i+1];
    // The query itself flips a positive table first; aim at the flipped values.
    if (depth_tbl[n >> 1] > 0) begin
      a = -a;
      b = -b;
    end
    r = $urandom_range(0, 99);
    if (r < 60) t = a + ((b - a) * longint'($urandom_range(0, 1024))) / 1024;
    else if (r < 72) t = a;
    else if (r < 82) t = b;
    else if (r < 86) t = a - longint'($urandom_range(1, 1 << 24));
    else if (r < 90) t = b + longint'($urandom_range(1, 1 << 24));
    else return $urandom;
    return DEPTH_W'(t);
  endfunction

  function automatic logic [COLUMN_W-1:0] pick_column();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Every result word is checked against the oldest expectation.
  always @(posedge clk) begin
    bracket_res_t want;
    if (!rst && done) begin
      if (pending_brackets.size() == 0) begin
        report_mismatch("result word with nothing pending, lower_index", lower_index, 0);
      end else begin
        want = pending_brackets.pop_front();
        if (lower_index !== want.lo) report_mismatch("lower_index", lower_index, want.lo);
        if (upper_index !== want.hi) report_mismatch("upper_index", upper_index, want.hi);
        if (lower_weight !== want.w) report_mismatch("lower_weight", lower_weight, want.w);
        if (last_point_res !== want.last)
          report_mismatch("last_point_res", last_point_res, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    bracket_res_t none;
    logic [LC_W-1:0] lc;
    logic [SL_W-1:0] sl;
    int n, nq, mode, r, i, j;
    logic lp;

    none        = '0;
    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= ACT_LOAD;
    level       <= '0;
    depth_value <= '0;
    column      <= '0;
    last_point  <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;

    for (i = 0; i < TABLE_DEPTH; i++) depth_tbl[i] = '0;
    bracket = 0;
    lc_reg  = LEVEL_COUNT_RST;
    sl_reg  = SLICE_LEN_RST;

    // Directed plan. It starts from the reset setting of two levels and a
    // slice length of one, so the indexes there are just the column and the
    // column plus one. Loading 0 and 10.0 makes the middle level positive,
    // and the first query flips the table to 0 and -10.0.
    add_row(ROW_LOAD,  0, 32'h0000_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  1, 32'h000A_0000, 0, 0, 0, 0, 0, 0);
    // Halfway between the two levels, at the widest column.
    add_row(ROW_QUERY, 0, 32'hFFFB_0000, '1, 0, 1, 28'h3F_FFFF, 28'h40_0000, 17'h0_8000);
    // On the upper level, on the lower level, then above and below the span.
    add_row(ROW_QUERY, 0, 32'h0000_0000, 0, 0, 1, 0, 1, WEIGHT_ONE);
    add_row(ROW_QUERY, 0, 32'hFFF6_0000, 0, 0, 1, 0, 1, WEIGHT_ZERO);
    add_row(ROW_QUERY, 0, DEPTH_MAX,     5, 0, 1, 5, 6, WEIGHT_ONE);
    add_row(ROW_QUERY, 0, DEPTH_MIN,     0, 1, 1, 0, 1, WEIGHT_ZERO);
    // The most negative level saturates when the table is flipped.
    add_row(ROW_LOAD,  0, DEPTH_MIN,     0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  1, 32'h0005_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 32'h0000_0000, 0, 1, 0, 0, 0, 0);
    // Equal neighbours give the full weight.
    add_row(ROW_LOAD,  0, 32'hFFFD_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  1, 32'hFFFD_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 32'hFFFD_0000, 0, 1, 1, 0, 1, WEIGHT_ONE);
    // Four levels with a zero slice length, so both indexes are the column;
    // the undecoded register indexes must change nothing.
    add_row(ROW_SETREG, REG_LEVEL_COUNT, 32'd4,       0, 0, 0, 0, 0, 0);
    add_row(ROW_SETREG, REG_SLICE_LEN,   32'd0,       0, 0, 0, 0, 0, 0);
    add_row(ROW_SETREG, REG_SPARE_A,     32'h7F_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SETREG, REG_SPARE_B,     32'h55,      0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  0, 32'h0000_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  1, 32'h000A_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  2, 32'h0014_0000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD,  3, 32'h001E_0000, 0, 0, 0, 0, 0, 0);
    // Walk up from level 0 to the deepest pair, halfway between -20 and -30.
    add_row(ROW_QUERY, 0, 32'hFFE7_0000, 22'h2A_AAAA, 0, 1,
            28'h2A_AAAA, 28'h2A_AAAA, 17'h0_8000);
    // Walk back down, then up again so that the bracket level is left at 2.
    add_row(ROW_QUERY, 0, 32'hFFFB_0000, 22'h15_5555, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 32'hFFE7_0000, 22'h00_0001, 0, 0, 0, 0, 0);
    // Three levels make the stale bracket level clamp to 1; the slice length
    // is set to its largest value.
    add_row(ROW_SETREG, REG_LEVEL_COUNT, 32'd3,       0, 0, 0, 0, 0, 0);
    add_row(ROW_SETREG, REG_SLICE_LEN,   32'h7F_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 32'hFFF1_0000, '1, 1, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_SETREG) begin
        if (i == 0 || plan[i-1].kind != ROW_SETREG) drain_block();
        write_reg(plan[i].addr[CFG_IDX_W-1:0], plan[i].value[CFG_DATA_W-1:0]);
        if (i == plan.size() - 1 || plan[i+1].kind != ROW_SETREG) cfg_valid <= 1'b0;
      end else begin
        send_word(plan[i].kind == ROW_QUERY ? ACT_QUERY : ACT_LOAD, plan[i].addr,
                  plan[i].value, plan[i].col, plan[i].last, plan[i].typed, plan[i].want);
        pause_maybe();
      end
    end

    // Random part. First every table entry gets a value, so that no later
    // query can read a level that was never written, whatever the count.
    items_sent = 0;
    make_profile();
    for (i = 0; i < TABLE_DEPTH; i++) begin
      send_word(ACT_LOAD, i, profile[i], pick_column(), $urandom_range(0, 1), 1'b0, none);
      pause_maybe();
    end

    while (items_sent < RANDOM_WORDS) begin
      // A new setting per phase: mostly few levels, with the extremes and
      // the out-of-range counts mixed in. Upper data bits of the level count
      // write are junk that the register must drop.
      r = $urandom_range(0, 99);
      if (r < 10) lc = 2;
      else if (r < 18) lc = 64;
      else if (r < 24) lc = $urandom_range(0, 1);
      else if (r < 30) lc = $urandom_range(65, 127);
      else if (r < 70) lc = $urandom_range(3, 10);
      else lc = $urandom_range(2, 64);
      r = $urandom_range(0, 99);
      if (r < 10) sl = 0;
      else if (r < 20) sl = 1;
      else if (r < 30) sl = '1;
      else if (r < 70) sl = $urandom_range(1, 64);
      else sl = $urandom;

      drain_block();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_LEVEL_COUNT, {16'($urandom), lc});
        cfg_gap_maybe();
        write_reg(REG_SLICE_LEN, sl);
      end else begin
        write_reg(REG_SLICE_LEN, sl);
        cfg_gap_maybe();
        write_reg(REG_LEVEL_COUNT, {16'($urandom), lc});
      end
      if ($urandom_range(0, 99) < 30) begin
        cfg_gap_maybe();
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      end
      cfg_valid <= 1'b0;

      // The stretch with no sender gaps at all.
      calm = (items_sent >= 150 && items_sent < 260);
      n    = eff_levels();

      // Reload the active levels, touch up a few, or keep the old table.
      mode = $urandom_range(0, 99);
      make_profile();
      if (mode < 60) begin
        for (i = 0; i < n; i++) begin
          send_word(ACT_LOAD, i, profile[i], pick_column(), $urandom_range(0, 1), 1'b0, none);
          pause_maybe();
        end
      end else if (mode < 85) begin
        for (i = 0; i < $urandom_range(1, 4); i++) begin
          send_word(ACT_LOAD, $urandom_range(0, TABLE_DEPTH - 1), profile[i], pick_column(),
                    $urandom_range(0, 1), 1'b0, none);
          pause_maybe();
        end
      end

      // Queries in batches; a batch ends on a word marked last_point.
      nq = $urandom_range(10, 30);
      for (j = 0; j < nq; j++) begin
        lp = (j == nq - 1) || ($urandom_range(0, 5) == 0);
        send_word(ACT_QUERY, $urandom, pick_target(n), pick_column(), lp, 1'b0, none);
        pause_maybe();
      end
    end

    // Let every expected result arrive, then watch for stray result words
    // over one more worst-case query latency.
    drain_block();
    repeat (QUERY_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dbwf_pkg.sv
hw/rtl/dbwf_ram.sv
hw/rtl/dbwf_ctrl.sv
hw/rtl/dbwf_dp.sv
hw/rtl/depth_bracket_weight_finder_unit.sv
test/depth_bracket_weight_finder_unit_tb.sv
